[design/lockout_button_debouncer_top_assert.svh]
// assertion macros used by the checker file
`ifndef LOCKOUT_BUTTON_DEBOUNCER_TOP_ASSERT_SVH
`define LOCKOUT_BUTTON_DEBOUNCER_TOP_ASSERT_SVH

// clocked assertion, off while reset is applied
`define LBD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define LBD_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/lbd_pkg.sv]
// package: sizes, register map and shared types of the lockout debouncer
package lbd_pkg;

    localparam int NUM_PINS    = 16;
    localparam int COUNT_WIDTH = 10;

    localparam int PIN_W   = 16;
    localparam int TICKS_W = 10;
    localparam int LANES   = (NUM_PINS < PIN_W) ? NUM_PINS : PIN_W;
    localparam int CMP_W   = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_LOCKOUT = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE  = 3'd4;

    localparam logic [TICKS_W-1:0] RESET_LOCKOUT = 10'd50;
    localparam logic [PIN_W-1:0]   RESET_ENABLE  = 16'h0120;

    typedef struct packed {
        logic [TICKS_W-1:0] lockout_ticks;
        logic [PIN_W-1:0]   pin_enable;
    } t_cfg;

endpackage

[design/lbd_core.sv]
// per-pin lockout state and the next-state logic for one sample
module lbd_core
    import lbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [PIN_W-1:0] i_raw,
    input  logic             i_tick,
    input  t_cfg             i_cfg,
    output logic [PIN_W-1:0] o_debounced,
    output logic             o_changed
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [PIN_W-1:0]       r_stable;
    logic [PIN_W-1:0]       r_prev;
    logic [PIN_W-1:0]       r_locked;
    logic [COUNT_WIDTH-1:0] r_cnt [LANES];

    logic [PIN_W-1:0]       n_stable;
    logic [PIN_W-1:0]       n_prev;
    logic [PIN_W-1:0]       n_locked;
    logic [COUNT_WIDTH-1:0] n_cnt [LANES];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic                   w_edge;
        logic                   w_exp;
        logic [COUNT_WIDTH-1:0] w_cnt;

        assign w_edge = (i_raw[k] ^ r_prev[k]) & i_cfg.pin_enable[k] & ~r_locked[k];
        assign w_cnt  = (i_tick && (r_cnt[k] != CNT_MAX)) ?
                        r_cnt[k] + COUNT_WIDTH'(1) : r_cnt[k];
        assign w_exp  = r_locked[k] &&
                        (CMP_W'(w_cnt) >= CMP_W'(i_cfg.lockout_ticks));

        assign n_cnt[k]    = w_edge ? '0 : (r_locked[k] ? w_cnt : r_cnt[k]);
        assign n_stable[k] = w_edge ? ~r_stable[k] : (w_exp ? i_raw[k] : r_stable[k]);
        assign n_locked[k] = w_edge | (r_locked[k] & ~w_exp);
        assign n_prev[k]   = i_raw[k];
    end

    if (LANES < PIN_W) begin : g_unused
        assign n_stable[PIN_W-1:LANES] = '0;
        assign n_locked[PIN_W-1:LANES] = '0;
        assign n_prev[PIN_W-1:LANES]   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            r_prev   <= '0;
            r_locked <= '0;
            for (int k = 0; k < LANES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_step) begin
            r_stable <= n_stable;
            r_prev   <= n_prev;
            r_locked <= n_locked;
            for (int k = 0; k < LANES; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    assign o_debounced = n_stable;
    assign o_changed   = (n_stable != r_stable);

endmodule

[design/lockout_button_debouncer_top.sv]
// top level: sample channel, result channel and register port of the debouncer
//
// input channel: i_valid / o_stall with i_raw_pins and i_tick_strobe; a beat
// is taken at a clock edge with i_valid high and o_stall low
// result channel: o_valid / i_stall with o_debounced and o_changed, one result
// beat for every input beat, in order
// path: a beat lands in the input register at accept and its result is written
// to the output register, which drives o_valid, once that register may advance
// throughput: one beat per cycle unless i_stall holds a result; set by the single
// pass of per-pin logic between the input register and the output register
// stall: while i_stall holds a result, the input register still takes one
// more beat; o_stall rises only when that register is full and blocked
// reset (synchronous, i_rst_n low): both channels empty, all pin state and
// counts cleared, lockout_ticks back to 50 and pin_enable back to 0x0120
// registers: lockout_ticks at address 0, pin_enable at address 4; write only
// while no beat is in flight
module lockout_button_debouncer_top
    import lbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIN_W-1:0]  i_raw_pins,
    input  logic              i_tick_strobe,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIN_W-1:0]  o_debounced,
    output logic              o_changed,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [PIN_W-1:0] r_raw;
    logic             r_tick;
    logic             r_out_valid;
    logic [PIN_W-1:0] r_debounced;
    logic             r_changed;

    logic             w_adv;
    logic             w_take;
    logic             w_wr;
    logic [PIN_W-1:0] w_debounced;
    logic             w_changed;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_ticks <= RESET_LOCKOUT;
            r_cfg.pin_enable    <= RESET_ENABLE;
        end else if (w_wr) begin
            case (paddr)
                ADDR_LOCKOUT: r_cfg.lockout_ticks <= pwdata[TICKS_W-1:0];
                ADDR_ENABLE:  r_cfg.pin_enable    <= pwdata[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_LOCKOUT: prdata = DATA_W'(r_cfg.lockout_ticks);
            ADDR_ENABLE:  prdata = DATA_W'(r_cfg.pin_enable);
            default:      prdata = '0;
        endcase
    end

    assign w_adv   = ~r_out_valid | ~i_stall;
    assign o_stall = r_in_valid & ~w_adv;
    assign w_take  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_raw  <= i_raw_pins;
            r_tick <= i_tick_strobe;
        end
    end

    lbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv & r_in_valid),
        .i_raw       (r_raw),
        .i_tick      (r_tick),
        .i_cfg       (r_cfg),
        .o_debounced (w_debounced),
        .o_changed   (w_changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_debounced <= w_debounced;
            r_changed   <= w_changed;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_debounced = r_debounced;
    assign o_changed   = r_changed;

endmodule

[design/lbd_checker.sv]
// port-level checker for the debouncer top level and its bind
`include "lockout_button_debouncer_top_assert.svh"

module lbd_checker
    import lbd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIN_W-1:0] o_debounced,
    input logic             o_changed
);

    logic [PIN_W-1:0] r_last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_beat <= '0;
        end else if (o_valid && !i_stall) begin
            r_last_beat <= o_debounced;
        end
    end

    // held result keeps its value
    `LBD_ASSERT_CLK(a_hold, o_valid && i_stall |=> o_valid && $stable(o_debounced), "held result changed")
    `LBD_ASSERT_CLK(a_hold_chg, o_valid && i_stall |=> $stable(o_changed), "held changed flag moved")
    // changed flag follows the previous beat
    `LBD_ASSERT_CLK(a_changed, o_valid |-> (o_changed == (o_debounced != r_last_beat)), "changed flag wrong")
    // output channel empty after reset
    `LBD_ASSERT_ANY(a_reset, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind lockout_button_debouncer_top lbd_checker u_lbd_checker (.*);
